// ===== design/assert_macros.svh =====
// Assertion macros used by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== design/vrptw_pkg.sv =====
// Package: constants and types of the route-split fitness evaluator.
`timescale 1ns / 1ps
package vrptw_pkg;
    localparam int MAX_NODES = 128;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int COST_AW = 2 * NODE_W;

    localparam logic [1:0] REQ_NODE   = 2'd0;
    localparam logic [1:0] REQ_COST   = 2'd1;
    localparam logic [1:0] REQ_VISIT  = 2'd2;
    localparam logic [1:0] REQ_FINISH = 2'd3;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_FLEET    = 2'd1;
    localparam logic [1:0] CFG_MODE     = 2'd2;

    localparam logic [15:0] CAPACITY_RST = 16'd200;
    localparam logic [7:0]  FLEET_RST    = 8'd25;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRY,
        S_CLOSE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [15:0] demand;
        logic [31:0] ready;
        logic [31:0] due;
        logic [31:0] service;
    } node_rec_t;
endpackage

// ===== design/vrptw_route_split_fitness.sv =====
// Top level: node and cost memories with the greedy route-split sequencer.
// A visit request runs S_TRY; a vehicle change adds S_CLOSE and S_TRY, a failed retry
// one more S_CLOSE. Finish: done is registered as S_FIN ends; loads write on accept.
// One leg read per cycle on the single cost read port; requests are taken only when idle.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset sets default config and clears running state; the tables stay unknown until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vrptw_route_split_fitness (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 req_type,
    input  logic [6:0]                 node_index,
    input  logic [6:0]                 to_index,
    input  logic [15:0]                node_demand,
    input  logic [31:0]                ready_time,
    input  logic [31:0]                due_time,
    input  logic [31:0]                service_time,
    input  logic [31:0]                travel_cost,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [15:0]                cfg_data,
    output logic                       done,
    output logic                       feasible,
    output logic [39:0]                route_cost,
    output logic [7:0]                 vehicles_used,
    output logic                       empty_route
);
    import vrptw_pkg::*;

    node_rec_t          node_mem [MAX_NODES];
    logic [31:0]        cost_mem [MAX_NODES * MAX_NODES];
    node_rec_t          node_rd_reg;
    logic [31:0]        leg_reg;
    logic [COST_AW-1:0] cost_raddr;

    state_t             state_reg, state_next;
    logic [15:0]        capacity_reg;
    logic [7:0]         fleet_reg;
    logic               mode_reg;
    logic [NODE_W-1:0]  cust_reg, cust_next;
    logic [31:0]        clock_reg, clock_next;
    logic [15:0]        load_reg, load_next;
    logic [NODE_W-1:0]  last_reg, last_next;
    logic [7:0]         vnum_reg, vnum_next;
    logic [31:0]        largest_reg, largest_next;
    logic [39:0]        dist_reg, dist_next;
    logic               failed_reg, failed_next;
    logic               done_reg, done_next;
    logic               feasible_reg, feasible_next;
    logic [39:0]        cost_reg, cost_next;
    logic [7:0]         used_reg, used_next;
    logic               empty_reg, empty_next;

    logic               accept;
    logic [NODE_W-1:0]  n_in;
    logic [32:0]        arrival;
    logic [16:0]        load_sum;
    logic               fits;
    logic [31:0]        t_start;
    logic [32:0]        t_end;
    logic [31:0]        served_clock;
    logic [32:0]        ret_sum;
    logic [31:0]        ret_clock;
    logic [40:0]        dist_sum;
    logic [39:0]        dist_sat;
    logic [7:0]         vnum_inc;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign n_in      = node_index[NODE_W-1:0];

    assign done          = done_reg;
    assign feasible      = feasible_reg;
    assign route_cost    = cost_reg;
    assign vehicles_used = used_reg;
    assign empty_route   = empty_reg;

    // Memories
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_NODE)
        begin
            node_mem[n_in] <= '{demand: node_demand, ready: ready_time,
                                due: due_time, service: service_time};
        end
        if (accept)
        begin
            node_rd_reg <= node_mem[n_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_COST)
        begin
            cost_mem[{n_in, to_index[NODE_W-1:0]}] <= travel_cost;
        end
        leg_reg <= cost_mem[cost_raddr];
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RST;
            fleet_reg    <= FLEET_RST;
            mode_reg     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAPACITY: capacity_reg <= cfg_data;
                CFG_FLEET:    fleet_reg    <= cfg_data[7:0];
                CFG_MODE:     mode_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Datapath
    always_comb
    begin
        arrival      = {1'b0, clock_reg} + {1'b0, leg_reg};
        load_sum     = {1'b0, load_reg} + {1'b0, node_rd_reg.demand};
        fits         = (arrival <= {1'b0, node_rd_reg.due}) &&
                       (load_sum <= {1'b0, capacity_reg});
        t_start      = (arrival[31:0] < node_rd_reg.ready) ? node_rd_reg.ready : arrival[31:0];
        t_end        = {1'b0, t_start} + {1'b0, node_rd_reg.service};
        served_clock = t_end[32] ? 32'hFFFF_FFFF : t_end[31:0];
        ret_sum      = {1'b0, clock_reg} + {1'b0, leg_reg};
        ret_clock    = ret_sum[32] ? 32'hFFFF_FFFF : ret_sum[31:0];
        dist_sum     = {1'b0, dist_reg} + {9'd0, leg_reg};
        dist_sat     = dist_sum[40] ? 40'hFF_FFFF_FFFF : dist_sum[39:0];
        vnum_inc     = (vnum_reg < 8'd255) ? vnum_reg + 8'd1 : vnum_reg;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cust_reg     <= '0;
            clock_reg    <= '0;
            load_reg     <= '0;
            last_reg     <= '0;
            vnum_reg     <= '0;
            largest_reg  <= '0;
            dist_reg     <= '0;
            failed_reg   <= 1'b0;
            done_reg     <= 1'b0;
            feasible_reg <= 1'b0;
            cost_reg     <= '0;
            used_reg     <= '0;
            empty_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cust_reg     <= cust_next;
            clock_reg    <= clock_next;
            load_reg     <= load_next;
            last_reg     <= last_next;
            vnum_reg     <= vnum_next;
            largest_reg  <= largest_next;
            dist_reg     <= dist_next;
            failed_reg   <= failed_next;
            done_reg     <= done_next;
            feasible_reg <= feasible_next;
            cost_reg     <= cost_next;
            used_reg     <= used_next;
            empty_reg    <= empty_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cust_next     = cust_reg;
        clock_next    = clock_reg;
        load_next     = load_reg;
        last_next     = last_reg;
        vnum_next     = vnum_reg;
        largest_next  = largest_reg;
        dist_next     = dist_reg;
        failed_next   = failed_reg;
        done_next     = 1'b0;
        feasible_next = feasible_reg;
        cost_next     = cost_reg;
        used_next     = used_reg;
        empty_next    = empty_reg;
        cost_raddr    = {last_reg, {NODE_W{1'b0}}};

        case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == REQ_VISIT && !failed_reg)
                begin
                    cost_raddr = {last_reg, n_in};
                    cust_next  = n_in;
                    state_next = S_TRY;
                end
                else if (accept && req_type == REQ_FINISH)
                begin
                    state_next = S_FIN;
                end
            end
            S_TRY:
            begin
                if (fits)
                begin
                    load_next  = load_sum[15:0];
                    clock_next = served_clock;
                    last_next  = cust_reg;
                    if (!mode_reg)
                    begin
                        largest_next = (served_clock > largest_reg) ? served_clock : largest_reg;
                    end
                    else
                    begin
                        dist_next = dist_sat;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                clock_next = ret_clock;
                if (!mode_reg)
                begin
                    largest_next = (ret_clock > largest_reg) ? ret_clock : largest_reg;
                end
                else
                begin
                    dist_next = dist_sat;
                end
                vnum_next = vnum_inc;
                if (last_reg == '0 || vnum_inc >= fleet_reg)
                begin
                    failed_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    clock_next = '0;
                    load_next  = '0;
                    last_next  = '0;
                    cost_raddr = {{NODE_W{1'b0}}, cust_reg};
                    state_next = S_TRY;
                end
            end
            S_FIN:
            begin
                done_next     = 1'b1;
                feasible_next = !failed_reg;
                empty_next    = (last_reg == '0);
                used_next     = vnum_reg;
                cost_next     = '0;
                if (last_reg != '0)
                begin
                    if (!mode_reg)
                    begin
                        cost_next = {8'd0, (ret_clock > largest_reg) ? ret_clock : largest_reg};
                    end
                    else
                    begin
                        cost_next = dist_sat;
                    end
                    if (!failed_reg)
                    begin
                        used_next = vnum_inc;
                    end
                end
                clock_next   = '0;
                load_next    = '0;
                last_next    = '0;
                vnum_next    = '0;
                largest_next = '0;
                dist_next    = '0;
                failed_next  = 1'b0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CHK_NEXT(a_done_after_fin, clk, rst_n, state_reg == S_FIN, done_reg)
    `CHK_IMPL(a_done_src, clk, rst_n, done_reg, $past(state_reg == S_FIN))
    `CHK_NEXT(a_fail_sticky, clk, rst_n, failed_reg && state_reg != S_FIN, failed_reg)
    `CHK_IMPL(a_try_src, clk, rst_n, state_reg == S_TRY,
              $past(state_reg == S_IDLE) || $past(state_reg == S_CLOSE))
endmodule
